// ===== sv/midpoint_circle_point_generator_top_macros.svh =====
// assertion macros for the circle point generator
`ifndef MIDPOINT_CIRCLE_POINT_GENERATOR_TOP_MACROS_SVH
`define MIDPOINT_CIRCLE_POINT_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTH
// checked only out of reset
`define MCPG_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked at every edge, reset included
`define MCPG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCPG_ASSERT(lbl, clk, rstn, prop, msg)
`define MCPG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/mcpg_pkg.sv =====
`timescale 1ns / 1ps

package mcpg_pkg;

  // display size, compared against the 8-bit wrapped coordinate
  localparam logic [8:0] SCREEN_WIDTH  = 9'd128;
  localparam logic [8:0] SCREEN_HEIGHT = 9'd64;

  // decision value constants
  localparam logic [15:0] DEC_INIT    = 16'd3;
  localparam logic [15:0] DEC_INC_NEG = 16'd6;
  localparam logic [15:0] DEC_INC_POS = 16'd10;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // one step's worth of work handed to the point emitter
  typedef struct packed {
    logic       valid;
    logic       done;
    logic [7:0] cx;
    logic [7:0] cy;
    logic [7:0] u;
    logic [7:0] v;
  } burst_t;

endpackage

// ===== sv/midpoint_circle_point_generator_top.sv =====
`timescale 1ns / 1ps
// channel | handshake           | payload
// in      | in_valid / in_stall | in_command, in_center_x, in_center_y, in_radius
// out     | out_valid/out_stall | out_point_x, out_point_y, out_point_valid,
//         |                     | out_off_screen, out_done_res, out_last_of_step
// a start item yields no item; a step item yields eight points, one per cycle
// from the point emitter while out_stall is low; the next item is taken as the
// last point loads. a step on a finished or absent circle yields one done item.
// synchronous active-low reset clears the circle state and empties both stages.
// out_stall holds the output register; in_stall rises while a step burst is pending.

module midpoint_circle_point_generator_top import mcpg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [7:0] in_center_x,
  input  logic [7:0] in_center_y,
  input  logic [7:0] in_radius,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_point_x,
  output logic [7:0] out_point_y,
  output logic       out_point_valid,
  output logic       out_off_screen,
  output logic       out_done_res,
  output logic       out_last_of_step
);

  logic   in_acc;
  logic   burst_free;
  burst_t burst;
  cmd_t   command;

  assign in_stall = !burst_free;
  assign in_acc   = in_valid && !in_stall;
  assign command  = cmd_t'(in_command);

  mcpg_state u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .command  (command),
    .center_x (in_center_x),
    .center_y (in_center_y),
    .radius   (in_radius),
    .burst    (burst)
  );

  mcpg_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .burst_in         (burst),
    .burst_free       (burst_free),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_point_valid  (out_point_valid),
    .out_off_screen   (out_off_screen),
    .out_done_res     (out_done_res),
    .out_last_of_step (out_last_of_step)
  );

endmodule

// ===== sv/mcpg_state.sv =====
`timescale 1ns / 1ps

module mcpg_state import mcpg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  cmd_t       command,
  input  logic [7:0] center_x,
  input  logic [7:0] center_y,
  input  logic [7:0] radius,
  output burst_t     burst
);

  logic [7:0]  cx_r, cx_nxt;
  logic [7:0]  cy_r, cy_nxt;
  logic [8:0]  ox_r, ox_nxt;
  logic [8:0]  oy_r, oy_nxt;
  logic [15:0] dec_r, dec_nxt;
  logic        active_r, active_nxt;

  logic        x_gt_y;
  logic        finished;
  logic [9:0]  diff;
  logic [15:0] step_neg;
  logic [15:0] step_pos;

  always_comb begin
    // x is unsigned, y may have dropped to -1
    x_gt_y   = $signed({1'b0, ox_r}) > $signed({oy_r[8], oy_r});
    finished = !active_r || x_gt_y;
    diff     = {1'b0, ox_r} - {oy_r[8], oy_r};
    step_neg = dec_r + {5'b0, ox_r, 2'b00} + DEC_INC_NEG;
    step_pos = dec_r + {{4{diff[9]}}, diff, 2'b00} + DEC_INC_POS;

    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    dec_nxt    = dec_r;
    active_nxt = active_r;

    if (acc) begin
      unique case (command)
        CMD_START: begin
          cx_nxt     = center_x;
          cy_nxt     = center_y;
          ox_nxt     = 9'd0;
          oy_nxt     = {1'b0, radius};
          dec_nxt    = DEC_INIT - {7'b0, radius, 1'b0};
          active_nxt = 1'b1;
        end
        CMD_STEP: begin
          if (finished) begin
            active_nxt = 1'b0;
          end else begin
            ox_nxt = ox_r + 9'd1;
            if (dec_r[15]) begin
              dec_nxt = step_neg;
            end else begin
              dec_nxt = step_pos;
              oy_nxt  = oy_r - 9'd1;
            end
          end
        end
        default: ;
      endcase
    end

    burst.valid = acc && (command == CMD_STEP);
    burst.done  = finished;
    burst.cx    = cx_r;
    burst.cy    = cy_r;
    burst.u     = ox_r[7:0];
    burst.v     = oy_r[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= 8'd0;
      cy_r     <= 8'd0;
      ox_r     <= 9'd0;
      oy_r     <= 9'd0;
      dec_r    <= 16'd0;
      active_r <= 1'b0;
    end else begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      dec_r    <= dec_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

// ===== sv/mcpg_emit.sv =====
`timescale 1ns / 1ps
`include "midpoint_circle_point_generator_top_macros.svh"

module mcpg_emit import mcpg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  burst_t     burst_in,
  output logic       burst_free,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_point_x,
  output logic [7:0] out_point_y,
  output logic       out_point_valid,
  output logic       out_off_screen,
  output logic       out_done_res,
  output logic       out_last_of_step
);

  logic       burst_valid_r, burst_valid_nxt;
  logic       bdone_r;
  logic [7:0] bcx_r, bcy_r, bu_r, bv_r;
  logic [2:0] idx_r, idx_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] px_r, py_r;
  logic       pvalid_r, off_r, done_r, last_r;

  logic       out_load;
  logic       burst_last;
  logic [7:0] a, b, px, py;
  logic       off;

  always_comb begin
    out_load   = burst_valid_r && (!out_valid_r || !out_stall);
    burst_last = bdone_r || (idx_r == 3'd7);
    burst_free = !burst_valid_r || (out_load && burst_last);

    // upper half of the eight points swaps the two offsets
    a   = idx_r[2] ? bv_r : bu_r;
    b   = idx_r[2] ? bu_r : bv_r;
    px  = idx_r[1] ? (bcx_r - a) : (bcx_r + a);
    py  = idx_r[0] ? (bcy_r - b) : (bcy_r + b);
    off = ({1'b0, px} >= SCREEN_WIDTH) || ({1'b0, py} >= SCREEN_HEIGHT);

    if (burst_in.valid) begin
      burst_valid_nxt = 1'b1;
      idx_nxt         = 3'd0;
    end else if (out_load) begin
      burst_valid_nxt = !burst_last;
      idx_nxt         = idx_r + 3'd1;
    end else begin
      burst_valid_nxt = burst_valid_r;
      idx_nxt         = idx_r;
    end

    if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_valid_r <= 1'b0;
      idx_r         <= 3'd0;
      out_valid_r   <= 1'b0;
    end else begin
      burst_valid_r <= burst_valid_nxt;
      idx_r         <= idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_in.valid) begin
      bdone_r <= burst_in.done;
      bcx_r   <= burst_in.cx;
      bcy_r   <= burst_in.cy;
      bu_r    <= burst_in.u;
      bv_r    <= burst_in.v;
    end
    if (out_load) begin
      if (bdone_r) begin
        px_r     <= 8'd0;
        py_r     <= 8'd0;
        pvalid_r <= 1'b0;
        off_r    <= 1'b0;
        done_r   <= 1'b1;
        last_r   <= 1'b1;
      end else begin
        px_r     <= px;
        py_r     <= py;
        pvalid_r <= 1'b1;
        off_r    <= off;
        done_r   <= 1'b0;
        last_r   <= (idx_r == 3'd7);
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_point_x      = px_r;
  assign out_point_y      = py_r;
  assign out_point_valid  = pvalid_r;
  assign out_off_screen   = off_r;
  assign out_done_res     = done_r;
  assign out_last_of_step = last_r;

  `MCPG_ASSERT(a_no_burst_overwrite, clk, rst_n, burst_in.valid |-> (!burst_valid_r || (out_load && burst_last)), "step item taken while the previous burst still pending")
  `MCPG_ASSERT(a_done_idx_zero, clk, rst_n, (burst_valid_r && bdone_r) |-> (idx_r == 3'd0), "done burst advanced past its single result")
  `MCPG_ASSERT(a_burst_drains, clk, rst_n, (out_load && burst_last && !burst_in.valid) |=> !burst_valid_r, "burst stays busy after its last item")
  `MCPG_ASSERT(a_done_is_last, clk, rst_n, (out_valid_r && done_r) |-> (last_r && !pvalid_r && !off_r), "done item malformed")

endmodule
